[rtl/core/rmsn_pkg.sv]
// Shared constants, types and state codes of the RMS normalizer.
`default_nettype none

package rmsn_pkg;

	localparam int MAX_LEN = 4096;

	localparam int DATA_W  = 16;
	localparam int EPS_W   = 16;
	localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int SQ_W    = 2 * DATA_W;
	// A square of a Q8.8 value is at most 2^30, so the sum needs 30 bits plus the count width.
	localparam int SUM_W   = 30 + CNT_W;
	localparam int MS_W    = 32;
	localparam int ROOT_W  = MS_W / 2;
	localparam int RECIP_W = 31;
	localparam int PROD_W  = SQ_W + RECIP_W;
	localparam int SHIFT_OUT = 36;
	localparam int Y_W     = PROD_W - SHIFT_OUT;
	localparam int UNIT_W  = (CNT_W + 1 > ROOT_W + 3) ? CNT_W + 1 : ROOT_W + 3;
	localparam int STEP_W  = $clog2(SUM_W);

	localparam int DIV_STEPS   = SUM_W;
	localparam int SQRT_STEPS  = ROOT_W;
	localparam int RECIP_STEPS = RECIP_W;

	localparam logic [RECIP_W-1:0] RECIP_NUM = RECIP_W'(1) << 30;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_WEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SKIP,
		ST_MUL1,
		ST_ACCUM,
		ST_DIV,
		ST_MS,
		ST_SQRT,
		ST_RDIV,
		ST_MUL2,
		ST_SAT
	} state_t;

	typedef enum logic {
		UNIT_DIV,
		UNIT_SQRT
	} unit_mode_t;

	typedef struct packed {
		logic [UNIT_W-1:0] rem;
		logic [SUM_W-1:0]  acc;
		logic [ROOT_W-1:0] root;
	} unit_regs_t;

endpackage

`default_nettype wire

[rtl/core/rmsn_if.sv]
// Handshake channels of the RMS normalizer: input items and result items.
`default_nettype none

interface rmsn_item_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] sample;
	logic [15:0] weight;
	logic        last;

	modport source (output valid, action, sample, weight, last, input ready);
	modport sink (input valid, action, sample, weight, last, output ready);
endinterface

interface rmsn_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] normalized;
	logic        end_of_vector;
	logic        clipped;
	logic        dropped;

	modport source (output valid, normalized, end_of_vector, clipped, dropped, input ready);
	modport sink (input valid, normalized, end_of_vector, clipped, dropped, output ready);
endinterface

`default_nettype wire

[rtl/core/rmsn_step_unit.sv]
// Shared shift, compare and subtract step for long division and integer square root.
`default_nettype none

module rmsn_step_unit
	import rmsn_pkg::*;
(
	input  unit_mode_t        mode,
	input  unit_regs_t        cur,
	input  logic [UNIT_W-1:0] divisor,
	output unit_regs_t        nxt
);

	logic [UNIT_W-1:0] shifted;
	logic [UNIT_W-1:0] trial;
	logic [UNIT_W-1:0] diff;
	logic              ge;

	always_comb begin
		shifted = '0;
		trial   = '0;
		case (mode)
			UNIT_DIV: begin
				shifted = {cur.rem[UNIT_W-2:0], cur.acc[SUM_W-1]};
				trial   = divisor;
			end
			UNIT_SQRT: begin
				// Two radicand bits per step; the trial value is 4*root + 1.
				shifted = {cur.rem[UNIT_W-3:0], cur.acc[SUM_W-1 -: 2]};
				trial   = UNIT_W'({cur.root, 2'b01});
			end
			default: begin
				shifted = '0;
				trial   = '0;
			end
		endcase

		ge   = (shifted >= trial);
		diff = shifted - trial;

		nxt.rem  = ge ? diff : shifted;
		nxt.acc  = cur.acc;
		nxt.root = cur.root;
		case (mode)
			UNIT_DIV: begin
				nxt.acc = {cur.acc[SUM_W-2:0], ge};
			end
			UNIT_SQRT: begin
				nxt.acc  = {cur.acc[SUM_W-3:0], 2'b00};
				nxt.root = {cur.root[ROOT_W-2:0], ge};
			end
			default: begin
				nxt.acc = cur.acc;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/rmsn_sample_mem.sv]
// Sample store: one write port and one read port with registered read data.
`default_nettype none

module rmsn_sample_mem
	import rmsn_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [MAX_LEN];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/core/rms_normalizer.sv]
// RMS normalizer top level: sequencer, sum and scale datapath, sample store.
`default_nettype none

// Two-pass RMS normalization. Samples (Q8.8, action 0) are written to a 4096-entry store
// while their squares are summed; each goes through a multiply and an accumulate state,
// and no new item is accepted until the block is idle again. The sample marked last
// also starts the per-vector sequence, in which one shared shift/compare/subtract unit
// does the mean-square division (one quotient bit per step), adds epsilon, takes the
// square root (one root bit per step) and forms the reciprocal. Each weight (Q2.14,
// action 1) then goes through a store read, x*w, the product times the reciprocal, and
// saturation into the output register, where it waits while the previous result has
// not been taken. A result can sit in the output register while the next item is
// accepted. Items of the wrong kind for the current pass go through a skip state and
// give no result. The store is not cleared after reset.
module rms_normalizer
	import rmsn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	rmsn_item_if.sink            item,
	rmsn_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [EPS_W-1:0]     cfg_wdata
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   read_idx_q;
	logic [SUM_W-1:0]   sum_q;
	logic [RECIP_W-1:0] recip_q;
	logic               draining_q;
	logic               overflow_q;
	logic [EPS_W-1:0]   eps_q;
	logic [STEP_W-1:0]  step_q;

	logic signed [DATA_W-1:0] data_q;
	logic                     last_q;
	logic                     store_q;
	logic                     end_q;
	logic                     drop_q;
	logic signed [SQ_W-1:0]   prod1_q;
	logic signed [PROD_W-1:0] prod2_q;
	unit_regs_t               ureg_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_norm_q;
	logic              out_end_q;
	logic              out_clip_q;
	logic              out_drop_q;

	logic              accept;
	logic              is_sample;
	logic              is_weight;
	logic              has_room;
	logic              out_load;
	logic              step_last;
	logic [SUM_W-1:0]  sum_next;
	logic [MS_W-1:0]   ms;
	logic [Y_W-1:0]    y_full;
	logic              y_clip;
	logic [DATA_W-1:0] y_sat;
	logic [DATA_W-1:0] rd_data;
	logic [UNIT_W-1:0] unit_divisor;
	unit_mode_t        unit_mode;
	unit_regs_t        unit_nxt;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign is_sample  = (item.action == ACT_SAMPLE) && !draining_q;
	assign is_weight  = (item.action == ACT_WEIGHT) && draining_q;
	assign has_room   = (count_q < CNT_W'(MAX_LEN));
	assign step_last  = (step_q == '0);

	assign sum_next = sum_q + (store_q ? SUM_W'($unsigned(prod1_q)) : '0);
	assign ms       = ureg_q.acc[MS_W-1:0] + MS_W'(eps_q);

	// Floor of the product over 2^36 is an arithmetic shift; then saturate to 16 bits.
	assign y_full = prod2_q[PROD_W-1:SHIFT_OUT];
	assign y_clip = !((&y_full[Y_W-1:DATA_W-1]) || !(|y_full[Y_W-1:DATA_W-1]));
	assign y_sat  = y_clip ? (y_full[Y_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
	                                         : {1'b0, {(DATA_W-1){1'b1}}})
	                       : y_full[DATA_W-1:0];

	assign unit_mode    = (state_q == ST_SQRT) ? UNIT_SQRT : UNIT_DIV;
	assign unit_divisor = (state_q == ST_DIV) ? UNIT_W'(count_q) : UNIT_W'(ureg_q.root);

	rmsn_step_unit u_step (
		.mode    (unit_mode),
		.cur     (ureg_q),
		.divisor (unit_divisor),
		.nxt     (unit_nxt)
	);

	rmsn_sample_mem u_mem (
		.clk   (clk),
		.we    (accept && is_sample && has_room),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (item.sample),
		.raddr (read_idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (is_sample || is_weight) ? ST_MUL1 : ST_SKIP;
				end
			end
			ST_SKIP: begin
				state_d = ST_IDLE;
			end
			ST_MUL1: begin
				state_d = draining_q ? ST_MUL2 : ST_ACCUM;
			end
			ST_ACCUM: begin
				state_d = last_q ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (step_last) begin
					state_d = ST_MS;
				end
			end
			ST_MS: begin
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (step_last) begin
					state_d = ST_RDIV;
				end
			end
			ST_RDIV: begin
				if (step_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL2: begin
				state_d = ST_SAT;
			end
			ST_SAT: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Vector state, configuration, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			read_idx_q  <= '0;
			sum_q       <= '0;
			recip_q     <= '0;
			draining_q  <= 1'b0;
			overflow_q  <= 1'b0;
			eps_q       <= EPS_W'(1);
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				eps_q <= cfg_wdata;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && is_sample) begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
					end
					if (accept && is_weight) begin
						read_idx_q <= read_idx_q + CNT_W'(1);
					end
				end
				ST_ACCUM: begin
					sum_q  <= sum_next;
					step_q <= STEP_W'(DIV_STEPS - 1);
				end
				ST_DIV: begin
					step_q <= step_q - STEP_W'(1);
				end
				ST_MS: begin
					step_q <= STEP_W'(SQRT_STEPS - 1);
				end
				ST_SQRT: begin
					step_q <= step_last ? STEP_W'(RECIP_STEPS - 1) : step_q - STEP_W'(1);
				end
				ST_RDIV: begin
					step_q <= step_q - STEP_W'(1);
					if (step_last) begin
						recip_q    <= (ureg_q.root == '0) ? '0 : unit_nxt.acc[RECIP_W-1:0];
						draining_q <= 1'b1;
						read_idx_q <= '0;
					end
				end
				ST_SAT: begin
					// The result for the final stored sample ends the vector.
					if (out_load && end_q) begin
						draining_q <= 1'b0;
						sum_q      <= '0;
						count_q    <= '0;
						read_idx_q <= '0;
						overflow_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Operands, products, shared-unit registers and output payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					data_q  <= (item.action == ACT_WEIGHT) ? item.weight : item.sample;
					last_q  <= item.last;
					store_q <= has_room;
					end_q   <= ((read_idx_q + CNT_W'(1)) >= count_q);
					drop_q  <= overflow_q;
				end
			end
			ST_MUL1: begin
				prod1_q <= SQ_W'(draining_q ? $signed(rd_data) : data_q) * SQ_W'(data_q);
			end
			ST_ACCUM: begin
				ureg_q.rem  <= '0;
				ureg_q.acc  <= sum_next;
				ureg_q.root <= '0;
			end
			ST_DIV: begin
				ureg_q <= unit_nxt;
			end
			ST_MS: begin
				ureg_q.rem  <= '0;
				ureg_q.acc  <= SUM_W'(ms) << (SUM_W - MS_W);
				ureg_q.root <= '0;
			end
			ST_SQRT: begin
				if (step_last) begin
					ureg_q.rem  <= '0;
					ureg_q.acc  <= SUM_W'(RECIP_NUM) << (SUM_W - RECIP_W);
					ureg_q.root <= unit_nxt.root;
				end else begin
					ureg_q <= unit_nxt;
				end
			end
			ST_RDIV: begin
				ureg_q <= unit_nxt;
			end
			ST_MUL2: begin
				prod2_q <= PROD_W'(prod1_q) * PROD_W'($signed({1'b0, recip_q}));
			end
			ST_SAT: begin
				if (out_load) begin
					out_norm_q <= y_sat;
					out_end_q  <= end_q;
					out_clip_q <= y_clip;
					out_drop_q <= drop_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid         = out_valid_q;
	assign result.normalized    = out_norm_q;
	assign result.end_of_vector = out_end_q;
	assign result.clipped       = out_clip_q;
	assign result.dropped       = out_drop_q;

endmodule

`default_nettype wire

[rtl/core/rmsn_checker.sv]
// Port-level checks of the RMS normalizer, attached to the top level by bind.
`default_nettype none

module rmsn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [15:0] result_normalized,
	input logic        result_end_of_vector,
	input logic        result_clipped,
	input logic        result_dropped
);

	// A pending result stays offered until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before its transaction completed");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_normalized)
			&& $stable(result_end_of_vector) && $stable(result_clipped)
			&& $stable(result_dropped))
		else $error("result payload changed while stalled");

	// Every accepted item makes the block busy in the cycle after it is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("ready stayed high right after an input transaction");

	// A clipped result carries one of the two saturation values.
	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_clipped |->
			(result_normalized == 16'h7fff) || (result_normalized == 16'h8000))
		else $error("clipped result is not a saturation value");

endmodule

bind rms_normalizer rmsn_checker u_rmsn_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.item_valid           (item.valid),
	.item_ready           (item.ready),
	.result_valid         (result.valid),
	.result_ready         (result.ready),
	.result_normalized    (result.normalized),
	.result_end_of_vector (result.end_of_vector),
	.result_clipped       (result.clipped),
	.result_dropped       (result.dropped)
);

`default_nettype wire

[tb/rms_normalizer_tb.sv]
// Self-checking regression for the RMS normalizer: directed, capacity and random vectors.
`default_nettype none

module rms_normalizer_tb
	import rmsn_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT   = 2000000;
	localparam int unsigned SETTLE_CYCLES = 128;
	localparam int unsigned RANDOM_ITEMS  = 700;

	typedef struct packed {
		logic [15:0] normalized;
		logic        end_of_vector;
		logic        clipped;
		logic        dropped;
	} norm_result_t;

	typedef enum {VEC_FULL, VEC_SMALL, VEC_ZERO, VEC_SPARSE} vec_style_t;

	// Tracks the stored vector, its sum of squares and 1/rms, and queues the
	// normalized elements the block owes us.
	class rmsnorm_tracker;
		logic [15:0]      stored_x [MAX_LEN];
		longint           square_sum;
		int unsigned      n_stored;
		int unsigned      read_pos;
		longint           reciprocal;
		bit               draining;
		bit               overflowed;
		logic [EPS_W-1:0] epsilon;
		norm_result_t     pending_outputs [$];
		int unsigned      failures;

		function new();
			square_sum = 0;
			n_stored   = 0;
			read_pos   = 0;
			reciprocal = 0;
			draining   = 0;
			overflowed = 0;
			epsilon    = 1;
			failures   = 0;
		endfunction

		function void take_item(logic action, logic [15:0] sample, logic [15:0] weight,
				logic last);
			longint       xs;
			longint       ms;
			longint       rem;
			longint       root;
			longint       probe;
			longint       y;
			norm_result_t out;
			if (action == ACT_SAMPLE) begin
				if (draining)
					return;
				xs = longint'($signed(sample));
				if (n_stored < MAX_LEN) begin
					stored_x[n_stored] = sample;
					n_stored++;
					square_sum += xs * xs;
				end else begin
					overflowed = 1;
				end
				if (last) begin
					ms = longint'(epsilon);
					if (n_stored != 0)
						ms += square_sum / longint'(n_stored);
					// Digit-by-digit integer square root of the mean square.
					rem   = ms;
					root  = 0;
					probe = 64'sd1 << 30;
					while (probe > rem)
						probe >>= 2;
					while (probe != 0) begin
						if (rem >= root + probe) begin
							rem -= root + probe;
							root = (root >> 1) + probe;
						end else begin
							root >>= 1;
						end
						probe >>= 2;
					end
					reciprocal = (root == 0) ? 0 : (64'sd1 << 30) / root;
					read_pos   = 0;
					draining   = 1;
				end
				return;
			end
			if (!draining)
				return;
			xs = 0;
			if (read_pos < n_stored)
				xs = longint'($signed(stored_x[read_pos]));
			// Arithmetic shift gives the floor of the division by 2^36.
			y = (xs * longint'($signed(weight)) * reciprocal) >>> 36;
			out.clipped = 1'b0;
			if (y > 32767) begin
				y = 32767;
				out.clipped = 1'b1;
			end else if (y < -32768) begin
				y = -32768;
				out.clipped = 1'b1;
			end
			out.normalized = y[15:0];
			read_pos++;
			out.end_of_vector = (read_pos >= n_stored);
			out.dropped = overflowed;
			pending_outputs.push_back(out);
			if (out.end_of_vector) begin
				draining   = 0;
				square_sum = 0;
				n_stored   = 0;
				read_pos   = 0;
				overflowed = 0;
			end
		endfunction

		function string describe(norm_result_t r);
			return $sformatf("normalized=%0d end_of_vector=%0b clipped=%0b dropped=%0b",
				$signed(r.normalized), r.end_of_vector, r.clipped, r.dropped);
		endfunction

		function void check_output(norm_result_t got);
			norm_result_t want;
			if (pending_outputs.size() == 0) begin
				failures++;
				$display("%0t: unexpected result %s", $time, describe(got));
				return;
			end
			want = pending_outputs.pop_front();
			if (got !== want) begin
				failures++;
				$display("%0t: expected %s", $time, describe(want));
				$display("%0t: actual   %s", $time, describe(got));
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [EPS_W-1:0] cfg_wdata;
	int unsigned      burst_left = 0;
	bit               gaps_on = 1;
	int unsigned      cycle_count = 0;
	rmsnorm_tracker   tracker = new();

	rmsn_item_if   item_ch();
	rmsn_result_if result_ch();

	rms_normalizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("rms_normalizer regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			tracker.check_output({result_ch.normalized, result_ch.end_of_vector,
				result_ch.clipped, result_ch.dropped});
	end

	// The receiver switches between several stall patterns, each for a random stretch.
	initial begin : receiver
		int unsigned mode_left;
		int unsigned recv_mode;
		int unsigned hold_left;
		bit          hold_low;
		mode_left = 0;
		recv_mode = 0;
		hold_left = 0;
		hold_low  = 0;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				recv_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 256);
			end
			mode_left--;
			case (recv_mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= 1'($urandom_range(0, 1));
				2: begin
					if (hold_left == 0) begin
						hold_low  = !hold_low;
						hold_left = hold_low ? $urandom_range(1, 24) : $urandom_range(1, 6);
					end
					hold_left--;
					result_ch.ready <= !hold_low;
				end
				default: result_ch.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic send_item(input logic action, input logic [15:0] sample,
			input logic [15:0] weight, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = 0;
			if (gaps_on)
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 3);
			if (gap != 0) begin
				@(negedge clk);
				item_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		@(negedge clk);
		item_ch.valid  <= 1'b1;
		item_ch.action <= action;
		item_ch.sample <= sample;
		item_ch.weight <= weight;
		item_ch.last   <= last;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		tracker.take_item(action, sample, weight, last);
	endtask

	// Stops the sender and lets every owed result and any trailing work finish.
	task automatic settle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (tracker.pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_epsilon(input logic [EPS_W-1:0] value);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.epsilon = value;
	endtask

	// One whole vector: the samples, then one weight per stored sample, with the
	// occasional item of the wrong kind mixed in.
	task automatic send_vector(input int unsigned len, input vec_style_t style);
		logic [15:0] x;
		logic [15:0] w;
		int unsigned hot_a;
		int unsigned hot_b;
		int unsigned n_kept;
		hot_a = $urandom_range(0, MAX_LEN - 1);
		hot_b = (hot_a + $urandom_range(1, MAX_LEN - 1)) % MAX_LEN;
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(ACT_WEIGHT, 16'($urandom), 16'($urandom), 1'($urandom));
			case (style)
				VEC_FULL:  x = 16'($urandom);
				VEC_SMALL: x = 16'($urandom_range(0, 8)) - 16'd4;
				VEC_ZERO:  x = 16'h0000;
				default: begin
					// Mostly zero with two hot entries, so rms is 1 and those can clip.
					// Samples past capacity are extremes that must not reach the sum.
					if (i >= MAX_LEN)
						x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
					else if (i == hot_a)
						x = 16'd90;
					else if (i == hot_b)
						x = -16'sd80;
					else
						case ($urandom_range(0, 15))
							0:       x = 16'h0001;
							1:       x = 16'hFFFF;
							default: x = 16'h0000;
						endcase
				end
			endcase
			send_item(ACT_SAMPLE, x, 16'($urandom), i == len - 1);
		end
		n_kept = (len < MAX_LEN) ? len : MAX_LEN;
		for (int unsigned i = 0; i < n_kept; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(ACT_SAMPLE, 16'($urandom), 16'($urandom), 1'($urandom));
			case ($urandom_range(0, 7))
				0:       w = 16'h7FFF;
				1:       w = 16'h8000;
				default: w = 16'($urandom);
			endcase
			send_item(ACT_WEIGHT, 16'($urandom), w, 1'($urandom));
		end
	endtask

	initial begin : stimulus
		int unsigned      random_items;
		int unsigned      len;
		logic [EPS_W-1:0] eps;
		random_items   = 0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		item_ch.valid  = 1'b0;
		item_ch.action = ACT_SAMPLE;
		item_ch.sample = '0;
		item_ch.weight = '0;
		item_ch.last   = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Epsilon at its reset value: extremes, and items of the wrong kind for the pass.
		send_item(ACT_WEIGHT, 16'h1234, 16'h7FFF, 1'b1);
		send_item(ACT_SAMPLE, 16'h7FFF, 16'hFFFF, 1'b0);
		send_item(ACT_SAMPLE, 16'h8000, 16'h0000, 1'b1);
		send_item(ACT_WEIGHT, 16'h0000, 16'h7FFF, 1'b0);
		send_item(ACT_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(ACT_WEIGHT, 16'hFFFF, 16'h8000, 1'b1);
		// Tiny negative product must round toward minus infinity.
		send_item(ACT_SAMPLE, 16'h0001, 16'h0000, 1'b1);
		send_item(ACT_WEIGHT, 16'h0000, 16'hFFFF, 1'b0);

		// With no epsilon a near-zero vector has a zero rms and yields zeros.
		set_epsilon(16'h0000);
		send_item(ACT_SAMPLE, 16'h0001, 16'h0000, 1'b0);
		send_item(ACT_SAMPLE, 16'h0000, 16'h0000, 1'b0);
		send_item(ACT_SAMPLE, 16'h0000, 16'h0000, 1'b1);
		send_item(ACT_WEIGHT, 16'h0000, 16'h7FFF, 1'b0);
		send_item(ACT_WEIGHT, 16'h0000, 16'h8000, 1'b0);
		send_item(ACT_WEIGHT, 16'h0000, 16'h0001, 1'b0);

		set_epsilon(16'hFFFF);
		send_item(ACT_SAMPLE, 16'h0100, 16'h0000, 1'b0);
		send_item(ACT_SAMPLE, 16'hFF00, 16'h0000, 1'b1);
		send_item(ACT_WEIGHT, 16'h0000, 16'h4000, 1'b0);
		send_item(ACT_WEIGHT, 16'h0000, 16'hC000, 1'b0);

		// One vector past capacity: the surplus is dropped and the hot entries can clip.
		set_epsilon(16'h0000);
		gaps_on = $urandom_range(0, 1);
		send_vector(MAX_LEN + 4, VEC_SPARSE);

		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0:       eps = 16'h0000;
				1:       eps = 16'hFFFF;
				2:       eps = 16'($urandom_range(0, 16));
				default: eps = 16'($urandom);
			endcase
			set_epsilon(eps);
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 12)) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
				send_vector(len, vec_style_t'($urandom_range(0, 2)));
				random_items += 2 * len;
			end
		end

		settle();
		if (tracker.failures == 0)
			$display("rms_normalizer regression: pass");
		else
			$display("rms_normalizer regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
